@@ rtl/leib_pkg.sv @@
// ----------------------------------------------------------------------------
// leib_pkg
// Shared types, constants and ring index helpers for the line edit buffer.
// ----------------------------------------------------------------------------
package leib_pkg;

  // Ring geometry
  localparam int QUEUE_DEPTH = 128;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  typedef logic [IDX_W-1:0] idx_t;

  // Key codes
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_DEL   = 8'd127;
  localparam logic [7:0] KEY_LF    = 8'd10;
  localparam logic [7:0] KEY_CR    = 8'd13;
  localparam logic [7:0] KEY_SPACE = 8'd32;

  // Result kinds
  localparam logic [1:0] RK_ECHO    = 2'd0;
  localparam logic [1:0] RK_DELIVER = 2'd1;
  localparam logic [1:0] RK_REFUSE  = 2'd2;

  // Input kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SEND  = 3'b100
  } state_t;

  // One planned result
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } slot_t;

  typedef logic [1:0] slot_idx_t;

  function automatic idx_t wrap_inc(input idx_t i);
    return (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t wrap_dec(input idx_t i);
    return (i == '0) ? idx_t'(QUEUE_DEPTH - 1) : i - idx_t'(1);
  endfunction

endpackage

@@ rtl/leib_ram.sv @@
// ----------------------------------------------------------------------------
// leib_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered (old data on a same-address collision).
// ----------------------------------------------------------------------------
module leib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/line_edit_input_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// line_edit_input_buffer_unit
// Line-editing input ring: read requests and key bytes in, echo, delivered
// and refusal results out. Ring bytes live in one RAM; head, tail and the
// read-waiting flag sit in registers.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------
//  input   | in_valid / in_stall | kind, key_byte
//  output  | out_valid/ out_stall| result_kind, data_byte, last
//
// An item is taken in the idle state only. The cycle after the transfer
// captures the RAM read of the head byte, then the results leave one per
// cycle from the output register while out_stall is low (up to 3 results
// per item); an item with no results leaves the sequencer idle.
// Reset clears head, tail, the waiting flag and the sequencer; the RAM is
// not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module line_edit_input_buffer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] key_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] data_byte,
  output logic       last
);
  import leib_pkg::*;

  state_t    state, state_next;
  idx_t      head, head_next;
  idx_t      tail, tail_next;
  logic      waiting, waiting_next;
  slot_t     plan [3];
  slot_t     plan_next [3];
  slot_idx_t last_idx, last_idx_next;
  slot_idx_t idx, idx_next;
  logic      use_mem, use_mem_next;
  logic      mem_idx, mem_idx_next;
  logic      out_valid_next;
  slot_t     out_slot, out_slot_next;
  logic      last_next;

  logic       ram_we;
  idx_t       ram_waddr;
  logic [7:0] ram_wdata;
  logic [7:0] ram_rdata;

  logic accept, out_xfer, empty, full, is_erase, is_crlf;

  assign accept   = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign empty    = (head == tail);
  assign full     = (wrap_inc(tail) == head);
  assign is_erase = (key_byte == KEY_BS) || (key_byte == KEY_DEL);
  assign is_crlf  = (key_byte == KEY_CR) || (key_byte == KEY_LF);

  // Line store; the read port always looks at the head entry
  leib_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(head),
    .rdata(ram_rdata)
  );

  // Decode the item, plan its results, then stream them out
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    waiting_next   = waiting;
    plan_next      = plan;
    last_idx_next  = last_idx;
    idx_next       = idx;
    use_mem_next   = use_mem;
    mem_idx_next   = mem_idx;
    out_valid_next = out_valid;
    out_slot_next  = out_slot;
    last_next      = last;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = key_byte;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          use_mem_next = 1'b0;
          mem_idx_next = 1'b0;
          if (kind == KIND_READ) begin
            if (!waiting) begin
              if (empty) begin
                waiting_next = 1'b1;
              end else begin
                // deliver head byte
                head_next     = wrap_inc(head);
                plan_next[0]  = '{kind: RK_DELIVER, data: 8'd0};
                last_idx_next = 2'd0;
                use_mem_next  = 1'b1;
                state_next    = ST_FETCH;
              end
            end
          end else if (!waiting) begin
            plan_next[0]  = '{kind: RK_REFUSE, data: 8'd0};
            last_idx_next = 2'd0;
            state_next    = ST_FETCH;
          end else if (is_erase) begin
            if (!empty) begin
              tail_next     = wrap_dec(tail);
              plan_next[0]  = '{kind: RK_ECHO, data: key_byte};
              plan_next[1]  = '{kind: RK_ECHO, data: KEY_SPACE};
              plan_next[2]  = '{kind: RK_ECHO, data: key_byte};
              last_idx_next = 2'd2;
              state_next    = ST_FETCH;
            end
          end else if ((is_crlf && !empty) || (!is_crlf && full)) begin
            // complete the line: pop head, append LF
            head_next     = wrap_inc(head);
            tail_next     = wrap_inc(tail);
            ram_we        = 1'b1;
            ram_wdata     = KEY_LF;
            waiting_next  = 1'b0;
            plan_next[0]  = '{kind: RK_ECHO, data: KEY_LF};
            plan_next[1]  = '{kind: RK_DELIVER, data: 8'd0};
            last_idx_next = 2'd1;
            use_mem_next  = 1'b1;
            mem_idx_next  = 1'b1;
            state_next    = ST_FETCH;
          end else if (is_crlf) begin
            waiting_next  = 1'b0;
            plan_next[0]  = '{kind: RK_ECHO, data: KEY_LF};
            plan_next[1]  = '{kind: RK_DELIVER, data: KEY_LF};
            last_idx_next = 2'd1;
            state_next    = ST_FETCH;
          end else begin
            // append and echo
            tail_next     = wrap_inc(tail);
            ram_we        = 1'b1;
            plan_next[0]  = '{kind: RK_ECHO, data: key_byte};
            last_idx_next = 2'd0;
            state_next    = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        // merge the head byte and load the first result
        if (use_mem) begin
          plan_next[slot_idx_t'(mem_idx)].data = ram_rdata;
        end
        out_slot_next  = plan_next[0];
        last_next      = (last_idx == 2'd0);
        idx_next       = 2'd0;
        out_valid_next = 1'b1;
        state_next     = ST_SEND;
      end
      ST_SEND: begin
        if (out_xfer) begin
          if (idx == last_idx) begin
            out_valid_next = 1'b0;
            state_next     = ST_IDLE;
          end else begin
            idx_next      = idx + 2'd1;
            out_slot_next = plan[idx + 2'd1];
            last_next     = ((idx + 2'd1) == last_idx);
          end
        end
      end
      default: begin
        state_next     = ST_IDLE;
        out_valid_next = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      waiting   <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      waiting   <= waiting_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    plan     <= plan_next;
    last_idx <= last_idx_next;
    use_mem  <= use_mem_next;
    mem_idx  <= mem_idx_next;
    out_slot <= out_slot_next;
    last     <= last_next;
  end

  assign result_kind = out_slot.kind;
  assign data_byte   = out_slot.data;

  // Checks
  a_valid_in_send: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_SEND))
    else $error("result shown outside the send state");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input taken while a result is pending");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last) |=> (!out_valid && (state == ST_IDLE)))
    else $error("result after the final one of an item");

  a_send_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((idx <= last_idx) && (last == (idx == last_idx))))
    else $error("result index past the planned count");

endmodule

@@ sim/line_edit_checker.sv @@
// ----------------------------------------------------------------------------
// line_edit_checker
// Watches both channels of the line edit buffer, keeps its own copy of the
// ring and the read-waiting flag, predicts the results of every input
// transfer and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module line_edit_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       kind,
  input  logic [7:0] key_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] result_kind,
  input  logic [7:0] data_byte,
  input  logic       last,
  output int         errors,
  output int         pending,
  output int         held_bytes,
  output logic       reader_waiting
);
  import leib_pkg::*;

  typedef struct packed {
    logic [1:0] rkind;
    logic [7:0] data;
    logic       eor;
  } edit_result_t;

  edit_result_t expected_q[$];

  // Shadow ring and read state
  logic [7:0] line_ram [QUEUE_DEPTH];
  idx_t       head_ptr;
  idx_t       tail_ptr;
  logic       waiting;

  function automatic idx_t step_fwd(input idx_t i);
    return idx_t'((int'(i) + 1) % QUEUE_DEPTH);
  endfunction

  function automatic int ring_level();
    return (int'(tail_ptr) - int'(head_ptr) + QUEUE_DEPTH) % QUEUE_DEPTH;
  endfunction

  task automatic add_expected(input logic [1:0] rk, input logic [7:0] d, input logic e);
    edit_result_t r;
    r.rkind = rk;
    r.data  = d;
    r.eor   = e;
    expected_q.push_back(r);
  endtask

  // Apply one input transfer to the shadow state and queue its results
  task automatic predict_edit(input logic k, input logic [7:0] b);
    logic [7:0] popped;
    logic       is_eol;
    int         used;
    used   = ring_level();
    is_eol = (b == KEY_CR) || (b == KEY_LF);
    if (k == KIND_READ) begin
      if (waiting)
        return;
      if (used == 0) begin
        waiting = 1'b1;
        return;
      end
      popped   = line_ram[head_ptr];
      head_ptr = step_fwd(head_ptr);
      add_expected(RK_DELIVER, popped, 1'b1);
      return;
    end
    if (!waiting) begin
      add_expected(RK_REFUSE, 8'd0, 1'b1);
      return;
    end
    // Erase the newest byte; nothing to erase on an empty ring
    if (b == KEY_BS || b == KEY_DEL) begin
      if (used == 0)
        return;
      tail_ptr = idx_t'((int'(tail_ptr) + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
      add_expected(RK_ECHO, b, 1'b0);
      add_expected(RK_ECHO, KEY_SPACE, 1'b0);
      add_expected(RK_ECHO, b, 1'b1);
      return;
    end
    // Complete the line: end of line on a non-empty ring, or a key on a full one
    if ((is_eol && used != 0) || (!is_eol && used == QUEUE_DEPTH - 1)) begin
      popped             = line_ram[head_ptr];
      head_ptr           = step_fwd(head_ptr);
      line_ram[tail_ptr] = KEY_LF;
      tail_ptr           = step_fwd(tail_ptr);
      waiting            = 1'b0;
      add_expected(RK_ECHO, KEY_LF, 1'b0);
      add_expected(RK_DELIVER, popped, 1'b1);
    end else if (is_eol) begin
      waiting = 1'b0;
      add_expected(RK_ECHO, KEY_LF, 1'b0);
      add_expected(RK_DELIVER, KEY_LF, 1'b1);
    end else begin
      line_ram[tail_ptr] = b;
      tail_ptr           = step_fwd(tail_ptr);
      add_expected(RK_ECHO, b, 1'b1);
    end
  endtask

  // Compare one output transfer with the oldest prediction
  task automatic check_result();
    edit_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result: kind %0d data 0x%02h last %0b",
               $time, result_kind, data_byte, last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (result_kind !== want.rkind || data_byte !== want.data || last !== want.eor) begin
      $display("%0t: result mismatch: expected kind %0d data 0x%02h last %0b",
               $time, want.rkind, want.data, want.eor);
      $display("%0t:                  actual   kind %0d data 0x%02h last %0b",
               $time, result_kind, data_byte, last);
      errors++;
    end
  endtask

  // Check outputs first so that a new transfer never masks a stray result
  always @(posedge clk) begin
    if (rst) begin
      head_ptr = '0;
      tail_ptr = '0;
      waiting  = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall)
        check_result();
      if (in_valid && !in_stall)
        predict_edit(kind, key_byte);
    end
    pending        = expected_q.size();
    held_bytes     = ring_level();
    reader_waiting = waiting;
  end

endmodule

@@ sim/tb_line_edit_input_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_line_edit_input_buffer_unit
// Drives read requests and key bytes into the line edit buffer in random
// bursts while the result side stalls in shifting patterns. A directed run
// covers refusal, waiting, erase, end of line and empty-ring cases, one line
// fills the ring to force a dropped key, then random editing sessions follow.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_line_edit_input_buffer_unit;
  import leib_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 240;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       kind;
  logic [7:0] key_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic       last;

  int   error_count;
  int   results_pending;
  int   bytes_held;
  logic read_pending;

  int cycle_count   = 0;
  int burst_left    = 0;
  int counted_items = 0;
  int stall_mode    = 0;
  int mode_timer    = 0;

  line_edit_input_buffer_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .key_byte    (key_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .data_byte   (data_byte),
    .last        (last)
  );

  line_edit_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .key_byte       (key_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .data_byte      (data_byte),
    .last           (last),
    .errors         (error_count),
    .pending        (results_pending),
    .held_bytes     (bytes_held),
    .reader_waiting (read_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result-side stall: switch between free flow, light, heavy and long stalls
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      mode_timer++;
      if (mode_timer % 50 == 0)
        stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((mode_timer % 20) < 8);
      endcase
    end
  end

  // Present one transfer at a falling edge; return at the falling edge after it
  task automatic send_item(input logic k, input logic [7:0] b);
    int   gap;
    logic ignored;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    ignored = (k == KIND_READ && read_pending) ||
              (k == KIND_KEY && read_pending && bytes_held == 0 &&
               (b == KEY_BS || b == KEY_DEL));
    if (!ignored)
      counted_items++;
    in_valid <= 1'b1;
    kind     <= k;
    key_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] plain_key();
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b == KEY_BS || b == KEY_DEL || b == KEY_CR || b == KEY_LF);
    return b;
  endfunction

  // Drain the ring with reads until a read is left waiting
  task automatic open_read();
    while (read_pending !== 1'b1)
      send_item(KIND_READ, 8'($urandom_range(0, 255)));
  endtask

  // Type a line with occasional erases, optionally closed by CR or LF
  task automatic type_line(input int len, input bit close_it);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 99) < 15)
        send_item(KIND_KEY, $urandom_range(0, 1) ? KEY_BS : KEY_DEL);
      else
        send_item(KIND_KEY, plain_key());
    end
    if (close_it)
      send_item(KIND_KEY, $urandom_range(0, 1) ? KEY_CR : KEY_LF);
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    kind     = KIND_READ;
    key_byte = 8'd0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: refusal, waiting, erase and end-of-line cases
    send_item(KIND_KEY, 8'h41);
    send_item(KIND_READ, 8'hFF);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_KEY, KEY_BS);
    send_item(KIND_KEY, 8'h00);
    send_item(KIND_KEY, 8'hFF);
    send_item(KIND_KEY, KEY_DEL);
    send_item(KIND_KEY, KEY_BS);
    send_item(KIND_KEY, KEY_CR);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_KEY, 8'h68);
    send_item(KIND_KEY, 8'h69);
    send_item(KIND_KEY, KEY_LF);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_KEY, 8'h7E);
    send_item(KIND_KEY, KEY_CR);
    send_item(KIND_READ, 8'hAA);
    send_item(KIND_KEY, 8'h80);
    send_item(KIND_KEY, KEY_LF);

    // Fill the ring, erase one, refill, then drop a key on the full ring
    open_read();
    while (bytes_held < QUEUE_DEPTH - 1)
      send_item(KIND_KEY, plain_key());
    send_item(KIND_KEY, KEY_BS);
    send_item(KIND_KEY, plain_key());
    send_item(KIND_KEY, plain_key());

    // Random editing sessions mixed with plain reads and noise
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          open_read();
          type_line($urandom_range(0, 10), $urandom_range(0, 9) != 0);
        end
        6, 7: begin
          repeat ($urandom_range(1, 8))
            send_item(KIND_READ, 8'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      endcase
    end

    // Drain and give stray results time to show
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/leib_pkg.sv
rtl/leib_ram.sv
rtl/line_edit_input_buffer_unit.sv
sim/line_edit_checker.sv
sim/tb_line_edit_input_buffer_unit.sv
